FILE: rtl/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants and types of the ray / box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_W         = 32;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int NUM_AXES        = 3;
    localparam int NUM_DIV         = 2 * NUM_AXES;
    localparam int DIV_BITS        = 32;
    localparam int REM_W           = DIV_BITS + DIFF_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = DIV_BITS / STEPS_PER_STAGE;
    // Stage 0 forms magnitudes, stage 1 detects overflow, then the bit stages.
    localparam int DIV_LAST        = DIV_STAGES + 1;

    localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [DIV_BITS-1:0] quo;
        logic                neg;
        logic                ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [NUM_DIV-1:0]              lane;
        logic [NUM_AXES-1:0][DIFF_W-1:0]     dmag;
        logic [NUM_AXES-1:0]                 par;
        logic                                par_ok;
    } div_stage_t;

endpackage

FILE: rtl/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Pipelined ray segment versus axis-aligned box test by the slab method.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock cycle while the output is not
// stalled and answers each with one hit bit, in order. The pipeline has 21
// register stages: the six slab divisions, which run as restoring dividers
// unrolled into 16 register stages of two quotient bits each, plus one stage
// for differences, one for overflow detection, one for saturation and
// ordering, one for the near/far reduction and the output register. The whole
// pipeline holds while a result waits to be taken.
module ray_box_slab_test
    import rbst_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_box_low_x,
    input  logic signed [COORD_W-1:0] s_box_low_y,
    input  logic signed [COORD_W-1:0] s_box_low_z,
    input  logic signed [COORD_W-1:0] s_box_high_x,
    input  logic signed [COORD_W-1:0] s_box_high_y,
    input  logic signed [COORD_W-1:0] s_box_high_z,
    input  logic signed [COORD_W-1:0] s_ray_start_x,
    input  logic signed [COORD_W-1:0] s_ray_start_y,
    input  logic signed [COORD_W-1:0] s_ray_start_z,
    input  logic signed [COORD_W-1:0] s_ray_end_x,
    input  logic signed [COORD_W-1:0] s_ray_end_y,
    input  logic signed [COORD_W-1:0] s_ray_end_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit
);

    logic en;

    logic signed [COORD_W-1:0] lo_v  [NUM_AXES];
    logic signed [COORD_W-1:0] hi_v  [NUM_AXES];
    logic signed [COORD_W-1:0] org_v [NUM_AXES];
    logic signed [COORD_W-1:0] dst_v [NUM_AXES];

    div_stage_t diff_next;
    div_stage_t pipe_reg  [DIV_LAST+1];
    div_stage_t pipe_next [DIV_LAST+1];
    logic [DIV_LAST:0] div_valid_reg;

    logic signed [COORD_W-1:0] tlo_reg [NUM_AXES];
    logic signed [COORD_W-1:0] thi_reg [NUM_AXES];
    logic signed [COORD_W-1:0] tlo_next [NUM_AXES];
    logic signed [COORD_W-1:0] thi_next [NUM_AXES];
    logic [NUM_AXES-1:0]       t_par_reg;
    logic                      t_par_ok_reg;
    logic                      t_valid_reg;

    logic signed [COORD_W-1:0] tnear_reg, tnear_next;
    logic signed [COORD_W-1:0] tfar_reg, tfar_next;
    logic                      any_np_reg;
    logic                      mm_par_ok_reg;
    logic                      mm_valid_reg;

    logic m_valid_reg;
    logic m_hit_reg, m_hit_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;

    assign lo_v[0]  = s_box_low_x;
    assign lo_v[1]  = s_box_low_y;
    assign lo_v[2]  = s_box_low_z;
    assign hi_v[0]  = s_box_high_x;
    assign hi_v[1]  = s_box_high_y;
    assign hi_v[2]  = s_box_high_z;
    assign org_v[0] = s_ray_start_x;
    assign org_v[1] = s_ray_start_y;
    assign org_v[2] = s_ray_start_z;
    assign dst_v[0] = s_ray_end_x;
    assign dst_v[1] = s_ray_end_y;
    assign dst_v[2] = s_ray_end_z;

    // Saturate a sign-magnitude quotient to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_quo(input div_lane_t l);
        logic signed [COORD_W-1:0] r;
        if (!l.neg) begin
            if (l.ovf || l.quo[DIV_BITS-1]) begin
                r = T_MAX;
            end else begin
                r = COORD_W'(l.quo);
            end
        end else begin
            if (l.ovf || (l.quo > DIV_BITS'(T_MIN))) begin
                r = T_MIN;
            end else begin
                r = COORD_W'(-l.quo);
            end
        end
        return r;
    endfunction

    // Differences, magnitudes and parallel-axis checks.
    always_comb begin
        logic [DIFF_W-1:0] dir;
        logic [DIFF_W-1:0] nlo;
        logic [DIFF_W-1:0] nhi;
        logic [DIFF_W-1:0] mlo;
        logic [DIFF_W-1:0] mhi;
        logic              org_in;
        logic              ok;
        diff_next = '0;
        ok = 1'b1;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            dir = {dst_v[ax][COORD_W-1], dst_v[ax]} - {org_v[ax][COORD_W-1], org_v[ax]};
            nlo = {lo_v[ax][COORD_W-1], lo_v[ax]} - {org_v[ax][COORD_W-1], org_v[ax]};
            nhi = {hi_v[ax][COORD_W-1], hi_v[ax]} - {org_v[ax][COORD_W-1], org_v[ax]};
            mlo = nlo[DIFF_W-1] ? -nlo : nlo;
            mhi = nhi[DIFF_W-1] ? -nhi : nhi;
            org_in = (lo_v[ax] <= org_v[ax]) && (org_v[ax] <= hi_v[ax]);
            diff_next.dmag[ax] = dir[DIFF_W-1] ? -dir : dir;
            diff_next.par[ax]  = (dir == '0);
            if ((dir == '0) && !org_in) begin
                ok = 1'b0;
            end
            diff_next.lane[2*ax].rem   = REM_W'(mlo) << FRAC_BITS;
            diff_next.lane[2*ax].neg   = nlo[DIFF_W-1] ^ dir[DIFF_W-1];
            diff_next.lane[2*ax+1].rem = REM_W'(mhi) << FRAC_BITS;
            diff_next.lane[2*ax+1].neg = nhi[DIFF_W-1] ^ dir[DIFF_W-1];
        end
        diff_next.par_ok = ok;
    end

    // Overflow detection, then two restoring quotient bits per stage.
    always_comb begin
        logic [REM_W-1:0] dsh;
        int               bitpos;
        pipe_next[0] = diff_next;
        for (int k = 1; k <= DIV_LAST; k++) begin
            pipe_next[k] = pipe_reg[k-1];
            for (int d = 0; d < NUM_DIV; d++) begin
                if (k == 1) begin
                    dsh = REM_W'(pipe_reg[k-1].dmag[d/2]) << DIV_BITS;
                    pipe_next[k].lane[d].ovf = (pipe_reg[k-1].lane[d].rem >= dsh);
                end else begin
                    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                        bitpos = DIV_BITS - 1 - STEPS_PER_STAGE * (k - 2) - j;
                        dsh = REM_W'(pipe_reg[k-1].dmag[d/2]) << bitpos;
                        if (pipe_next[k].lane[d].rem >= dsh) begin
                            pipe_next[k].lane[d].rem = pipe_next[k].lane[d].rem - dsh;
                            pipe_next[k].lane[d].quo[bitpos] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Saturate and order the slab parameters; parallel axes drop out.
    always_comb begin
        logic signed [COORD_W-1:0] t1;
        logic signed [COORD_W-1:0] t2;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            t1 = sat_quo(pipe_reg[DIV_LAST].lane[2*ax]);
            t2 = sat_quo(pipe_reg[DIV_LAST].lane[2*ax+1]);
            if (pipe_reg[DIV_LAST].par[ax]) begin
                tlo_next[ax] = T_MIN;
                thi_next[ax] = T_MAX;
            end else if (t1 > t2) begin
                tlo_next[ax] = t2;
                thi_next[ax] = t1;
            end else begin
                tlo_next[ax] = t1;
                thi_next[ax] = t2;
            end
        end
    end

    // Since tnear only rises and tfar only falls, testing the final pair is
    // the same as testing after every axis.
    always_comb begin
        tnear_next = T_MIN;
        tfar_next  = T_MAX;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            if (tlo_reg[ax] > tnear_next) begin
                tnear_next = tlo_reg[ax];
            end
            if (thi_reg[ax] < tfar_next) begin
                tfar_next = thi_reg[ax];
            end
        end
    end

    assign m_hit_next = mm_par_ok_reg &&
                        (!any_np_reg || ((tnear_reg <= tfar_reg) && !tfar_reg[COORD_W-1]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg <= '0;
            t_valid_reg   <= 1'b0;
            mm_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (en) begin
            div_valid_reg <= {div_valid_reg[DIV_LAST-1:0], s_valid};
            t_valid_reg   <= div_valid_reg[DIV_LAST];
            mm_valid_reg  <= t_valid_reg;
            m_valid_reg   <= mm_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= DIV_LAST; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                tlo_reg[ax] <= tlo_next[ax];
                thi_reg[ax] <= thi_next[ax];
            end
            t_par_reg     <= pipe_reg[DIV_LAST].par;
            t_par_ok_reg  <= pipe_reg[DIV_LAST].par_ok;
            tnear_reg     <= tnear_next;
            tfar_reg      <= tfar_next;
            any_np_reg    <= !(&t_par_reg);
            mm_par_ok_reg <= t_par_ok_reg;
            m_hit_reg     <= m_hit_next;
        end
    end

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_ready_when_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is taken");
    a_zero_dir_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_valid_reg[1] && (pipe_reg[1].dmag[0] == '0)) |-> pipe_reg[1].lane[0].ovf)
        else $error("zero direction did not flag overflow");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(div_valid_reg) && $stable(mm_valid_reg)))
        else $error("pipeline moved during a stall");
`endif

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Ray / box slab test testbench
// Drives ray segments and boxes into the slab test pipeline, predicts each
// hit bit with an independent fixed-point slab computation and compares the
// results in order, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import rbst_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = 21;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef struct {
        coord_t lo[3];
        coord_t hi[3];
        coord_t org[3];
        coord_t dst[3];
    } ray_box_t;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_lo[3];
    coord_t s_hi[3];
    coord_t s_org[3];
    coord_t s_dst[3];
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic   m_hit;

    logic   hit_queue[$];
    int     mismatches = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     n_hits = 0;
    bit     idle_enable = 1'b1;

    always #2 aclk = ~aclk;

    initial begin
        for (int a = 0; a < 3; a++) begin
            s_lo[a] = '0;
            s_hi[a] = '0;
            s_org[a] = '0;
            s_dst[a] = '0;
        end
    end

    ray_box_slab_test i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_box_low_x  (s_lo[0]),
        .s_box_low_y  (s_lo[1]),
        .s_box_low_z  (s_lo[2]),
        .s_box_high_x (s_hi[0]),
        .s_box_high_y (s_hi[1]),
        .s_box_high_z (s_hi[2]),
        .s_ray_start_x(s_org[0]),
        .s_ray_start_y(s_org[1]),
        .s_ray_start_z(s_org[2]),
        .s_ray_end_x  (s_dst[0]),
        .s_ray_end_y  (s_dst[1]),
        .s_ray_end_z  (s_dst[2]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit)
    );

    // Slab parameter: exact quotient truncated toward zero, then saturated.
    function automatic longint slab_t(longint num, longint dir);
        longint q;
        q = (num * (longint'(1) << FB)) / dir;
        if (q > longint'(T_MAX)) q = longint'(T_MAX);
        if (q < longint'(T_MIN)) q = longint'(T_MIN);
        return q;
    endfunction

    function automatic logic predict_hit(ray_box_t rb);
        longint tnear, tfar, lo, hi, org, dir, t1, t2, tmp;
        tnear = longint'(T_MIN);
        tfar = longint'(T_MAX);
        for (int a = 0; a < 3; a++) begin
            lo = rb.lo[a];
            hi = rb.hi[a];
            org = rb.org[a];
            dir = longint'(rb.dst[a]) - org;
            if (dir == 0) begin
                if (org < lo || org > hi) return 1'b0;
            end else begin
                t1 = slab_t(lo - org, dir);
                t2 = slab_t(hi - org, dir);
                if (t1 > t2) begin
                    tmp = t1;
                    t1 = t2;
                    t2 = tmp;
                end
                if (t1 > tnear) tnear = t1;
                if (t2 < tfar) tfar = t2;
                if (tnear > tfar || tfar < 0) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_ray(ray_box_t rb);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        for (int a = 0; a < 3; a++) begin
            s_lo[a] <= rb.lo[a];
            s_hi[a] <= rb.hi[a];
            s_org[a] <= rb.org[a];
            s_dst[a] <= rb.dst[a];
        end
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hit_queue = {hit_queue, predict_hit(rb)};
        n_sent++;
    endtask

    task automatic release_bus();
        s_valid <= 1'b0;
    endtask

    // Result sink: random stall bursts while idling is enabled.
    initial begin
        @(posedge aresetn);
        forever begin
            if (idle_enable && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected transaction, hit=%0b", m_hit);
            end else begin
                logic want;
                want = hit_queue.pop_front();
                n_checked++;
                if (m_hit) n_hits++;
                if (m_hit !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: transaction %0d hit expected %0b got %0b",
                                 n_checked - 1, want, m_hit);
                end
            end
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return T_MIN;
            1: return T_MAX;
            2: return coord_t'($urandom_range(0, 2)) - 1;
            3: return coord_t'($urandom);
            default: return coord_t'(int'($urandom_range(0, 40 << FB)) - (20 << FB));
        endcase
    endfunction

    // Mostly boxes in a small world with rays aimed near them; some wild values.
    function automatic ray_box_t rand_ray();
        ray_box_t rb;
        coord_t c, w;
        for (int a = 0; a < 3; a++) begin
            if ($urandom_range(0, 4) == 0) begin
                rb.lo[a] = rand_coord();
                rb.hi[a] = rand_coord();
                rb.org[a] = rand_coord();
                rb.dst[a] = rand_coord();
            end else begin
                c = coord_t'(int'($urandom_range(0, 20 << FB)) - (10 << FB));
                w = coord_t'($urandom_range(0, 4 << FB));
                rb.lo[a] = c - w;
                rb.hi[a] = ($urandom_range(0, 15) == 0) ? c - w - 1 : c + w;
                rb.org[a] = coord_t'(int'($urandom_range(0, 60 << FB)) - (30 << FB));
                case ($urandom_range(0, 5))
                    0: rb.dst[a] = rb.org[a];
                    1: rb.dst[a] = rb.org[a] + 1;
                    default:
                        rb.dst[a] = c + coord_t'(int'($urandom_range(0, 8 << FB)) - (4 << FB));
                endcase
            end
        end
        return rb;
    endfunction

    function automatic ray_box_t make_ray(coord_t lo, coord_t hi, coord_t org, coord_t dst);
        ray_box_t rb;
        for (int a = 0; a < 3; a++) begin
            rb.lo[a] = lo;
            rb.hi[a] = hi;
            rb.org[a] = org;
            rb.dst[a] = dst;
        end
        return rb;
    endfunction

    task automatic wait_drained();
        release_bus();
        while (hit_queue.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        ray_box_t rb;
        coord_t one;
        one = coord_t'(1 << FB);
        send_ray(make_ray(-one, one, -4 * one, 4 * one));      // straight through
        send_ray(make_ray(-one, one, 4 * one, 8 * one));       // pointing away
        send_ray(make_ray(-one, one, 0, 0));                   // degenerate inside
        send_ray(make_ray(-one, one, 2 * one, 2 * one));       // degenerate outside
        send_ray(make_ray(one, -one, 0, 0));                   // inverted, parallel
        send_ray(make_ray(one, -one, -4 * one, 4 * one));      // inverted, crossing
        send_ray(make_ray(T_MIN, T_MAX, T_MIN, T_MAX));        // full range
        send_ray(make_ray(T_MIN, T_MAX, T_MAX, T_MIN));
        send_ray(make_ray(T_MAX, T_MAX, T_MIN, T_MIN + 1));    // saturating quotient
        send_ray(make_ray(T_MIN, T_MIN, T_MAX, T_MAX - 1));
        send_ray(make_ray(0, 0, -one, 0));                     // tfar and tnear tie
        send_ray(make_ray(-one, 0, 0, one));                   // tfar zero
        send_ray(make_ray(-1, 1, 0, 1));
        send_ray(make_ray(-32'sd1, -32'sd1, -32'sd1, 32'sd0));
        rb = make_ray(-one, one, -4 * one, 4 * one);
        rb.org[1] = 2 * one;
        rb.dst[1] = 2 * one;                                   // parallel y outside
        send_ray(rb);
        rb = make_ray(-one, one, -4 * one, 4 * one);
        rb.dst[2] = -8 * one;                                  // slabs disjoint
        send_ray(rb);
        send_ray(make_ray(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555));
        send_ray(make_ray(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_ray(rand_ray());
    endtask

    task automatic test_streaming(int count);
        idle_enable = 1'b0;
        for (int i = 0; i < count; i++) send_ray(rand_ray());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(500);
        // Let the pipeline run dry before continuing.
        wait_drained();
        test_random(500);
        test_streaming(200);
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Sent %0d ray/box transactions, checked %0d results, %0d hits.",
                 n_sent, n_checked, n_hits);
        $display("Covered corner values, parallel and inverted slabs, idling and streaming.");
        if (mismatches == 0 && hit_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding.", hit_queue.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: files.f
rtl/rbst_pkg.sv
rtl/ray_box_slab_test.sv
test/tb_top.sv
